// ===== src/rfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rfg_pkg
// Shared widths, register indexes and elaboration-time helpers for the
// logarithmic RGB fade generator.
// ----------------------------------------------------------------------------
package rfg_pkg;

    localparam int STEP_W  = 16;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 16;

    typedef enum logic [1:0] {
        CFG_FADE_STEPS = 2'd0,
        CFG_MAX_RED    = 2'd1,
        CFG_MAX_GREEN  = 2'd2,
        CFG_MAX_BLUE   = 2'd3
    } t_cfg_idx;

    // Truncated integer square root, used only to build constants.
    function automatic logic [63:0] fx_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(m) with fb fraction bits; peaks below 2 give 0.
    function automatic logic [63:0] fx_log2(input int m, input int fb);
        logic [63:0] k;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] mm;
        mm   = 64'(m);
        k    = 64'd0;
        frac = 64'd0;
        if (m < 2) begin
            return 64'd0;
        end
        while ((mm >> (k + 64'd1)) != 64'd0) begin
            k = k + 64'd1;
        end
        y = (mm << fb) >> k;
        for (int j = 0; j < fb; j++) begin
            y    = (y * y) >> fb;
            frac = frac << 1;
            if (y >= (64'd2 << fb)) begin
                frac = frac | 64'd1;
                y    = y >> 1;
            end
        end
        return (k << fb) | frac;
    endfunction

    // 2^(2^-j) with fb fraction bits, by repeated square roots of 2.0.
    function automatic logic [63:0] fx_root(input int j, input int fb);
        logic [63:0] r;
        r = 64'd2 << fb;
        for (int i = 1; i <= j; i++) begin
            r = fx_isqrt(r << fb);
        end
        return r;
    endfunction

endpackage

// ===== src/rfg_div.sv =====
// ----------------------------------------------------------------------------
// rfg_div
// Pipelined restoring divider: one quotient bit per stage, one beat per clock.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module rfg_div
    import rfg_pkg::*;
#(
    parameter int QW = 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [QW+STEP_W-1:0] i_num,
    input  logic [STEP_W-1:0]    i_den,
    output logic                 o_valid,
    output logic [QW-1:0]        o_quot
);

    logic [STEP_W-1:0] r_rem [QW];
    logic [QW-1:0]     r_lo  [QW];
    logic              r_vld [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [STEP_W-1:0] rem_in;
        logic [QW-1:0]     lo_in;
        logic              vld_in;
        logic [STEP_W:0]   t;
        logic              q;
        logic [STEP_W-1:0] n_rem;
        logic [QW-1:0]     n_lo;

        if (g == 0) begin : g_first
            // The upper bits are below the divisor since the quotient fits.
            assign rem_in = i_num[QW+STEP_W-1:QW];
            assign lo_in  = i_num[QW-1:0];
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign lo_in  = r_lo[g-1];
            assign vld_in = r_vld[g-1];
        end

        assign t     = {rem_in, lo_in[QW-1]};
        assign q     = (t >= {1'b0, i_den});
        assign n_rem = q ? STEP_W'(t - {1'b0, i_den}) : t[STEP_W-1:0];
        assign n_lo  = {lo_in[QW-2:0], q};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
            r_rem[g] <= n_rem;
            r_lo[g]  <= n_lo;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_lo[QW-1];

endmodule

// ===== src/rfg_exp.sv =====
// ----------------------------------------------------------------------------
// rfg_exp
// Pipelined 2^e - 1 for one channel: one root multiply per fraction bit,
// then the integer shift, the minus one (held at zero) and the cut to eight bits.
// ----------------------------------------------------------------------------
module rfg_exp
    import rfg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [FRAC_BITS+2:0]  i_e,
    output logic                  o_valid,
    output logic [CH_W-1:0]       o_level
);

    localparam int PW = FRAC_BITS + 1;

    logic [PW-1:0]        r_p   [FRAC_BITS];
    logic [2:0]           r_ip  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_f   [FRAC_BITS];
    logic                 r_vld [FRAC_BITS];

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_stage
        localparam logic [PW-1:0] ROOT = PW'(fx_root(g + 1, FRAC_BITS));
        logic [PW-1:0]        p_in;
        logic [2:0]           ip_in;
        logic [FRAC_BITS-1:0] f_in;
        logic                 vld_in;
        logic [2*PW-1:0]      prod;
        logic [PW-1:0]        n_p;

        if (g == 0) begin : g_first
            assign p_in   = PW'(1) << FRAC_BITS;
            assign ip_in  = i_e[FRAC_BITS+2:FRAC_BITS];
            assign f_in   = i_e[FRAC_BITS-1:0];
            assign vld_in = i_valid;
        end else begin : g_next
            assign p_in   = r_p[g-1];
            assign ip_in  = r_ip[g-1];
            assign f_in   = r_f[g-1];
            assign vld_in = r_vld[g-1];
        end

        // Fraction bits are taken from the half weight downward.
        assign prod = (2*PW)'(p_in) * (2*PW)'(ROOT);
        assign n_p  = f_in[FRAC_BITS-1-g] ? prod[FRAC_BITS+PW-1:FRAC_BITS] : p_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
            r_p[g]  <= n_p;
            r_ip[g] <= ip_in;
            r_f[g]  <= f_in;
        end
    end

    logic [PW+6:0]   shifted;
    logic [CH_W-1:0] whole;
    logic [CH_W-1:0] n_level;
    logic            r_out_vld;
    logic [CH_W-1:0] r_level;

    assign shifted = (PW+7)'(r_p[FRAC_BITS-1]) << r_ip[FRAC_BITS-1];
    assign whole   = shifted[PW+6:FRAC_BITS];
    assign n_level = (whole == '0) ? '0 : whole - CH_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[FRAC_BITS-1];
        end
        r_level <= n_level;
    end

    assign o_valid = r_out_vld;
    assign o_level = r_level;

endmodule

// ===== src/rgb_log_fade_generator_core.sv =====
// ----------------------------------------------------------------------------
// rgb_log_fade_generator_core
// Maps a fade step to a packed RGB color on a logarithmic brightness curve.
// ----------------------------------------------------------------------------
// One fade step is taken every clock and busy never rises. Each result comes
// out as one beat per step, in step order, through stage A, stage B, the
// pipelined divider (one quotient bit per stage), the root multiplier chain
// (one fraction bit per stage) and the output registers. The result is shown
// for a single cycle with o_valid high and cannot be held off, so the
// receiver must take it then. The user must write registers only while no
// step is in flight; the block itself does not enforce it.
module rgb_log_fade_generator_core
    import rfg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [STEP_W-1:0]  i_step_index,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_valid,
    output logic [COLOR_W-1:0] o_packed_color
);

    localparam int LW = FRAC_BITS + 3;
    localparam int NW = LW + STEP_W;

    logic [STEP_W-1:0] r_fade_steps;
    logic [CH_W-1:0]   r_max_red;
    logic [CH_W-1:0]   r_max_green;
    logic [CH_W-1:0]   r_max_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_steps <= STEP_W'(255);
            r_max_red    <= CH_W'(255);
            r_max_green  <= CH_W'(255);
            r_max_blue   <= CH_W'(255);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FADE_STEPS: r_fade_steps <= i_cfg_data;
                CFG_MAX_RED:    r_max_red    <= i_cfg_data[CH_W-1:0];
                CFG_MAX_GREEN:  r_max_green  <= i_cfg_data[CH_W-1:0];
                CFG_MAX_BLUE:   r_max_blue   <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // log2 of every possible peak, built at elaboration.
    logic [LW-1:0] log_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_log
        localparam logic [LW-1:0] LV = LW'(fx_log2(g, FRAC_BITS));
        assign log_tab[g] = LV;
    end

    logic              accept;
    logic [STEP_W-1:0] n_step;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign n_step = (i_step_index > r_fade_steps) ? r_fade_steps : i_step_index;

    // Stage A: clamp the step and look up the peaks' logarithms.
    logic              r_a_vld;
    logic [STEP_W-1:0] r_a_step;
    logic [LW-1:0]     r_a_log_r;
    logic [LW-1:0]     r_a_log_g;
    logic [LW-1:0]     r_a_log_b;

    // Stage B: log2(peak) * step, ready for the divide by fade_steps.
    logic          r_b_vld;
    logic [NW-1:0] r_b_num_r;
    logic [NW-1:0] r_b_num_g;
    logic [NW-1:0] r_b_num_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
        end
        r_a_step  <= n_step;
        r_a_log_r <= log_tab[r_max_red];
        r_a_log_g <= log_tab[r_max_green];
        r_a_log_b <= log_tab[r_max_blue];
        r_b_num_r <= NW'(r_a_log_r) * NW'(r_a_step);
        r_b_num_g <= NW'(r_a_log_g) * NW'(r_a_step);
        r_b_num_b <= NW'(r_a_log_b) * NW'(r_a_step);
    end

    logic          div_vld_r, div_vld_g, div_vld_b;
    logic [LW-1:0] e_r, e_g, e_b;

    rfg_div #(.QW(LW)) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_b_vld), .i_num(r_b_num_r),
        .i_den(r_fade_steps), .o_valid(div_vld_r), .o_quot(e_r)
    );
    rfg_div #(.QW(LW)) u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_b_vld), .i_num(r_b_num_g),
        .i_den(r_fade_steps), .o_valid(div_vld_g), .o_quot(e_g)
    );
    rfg_div #(.QW(LW)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_b_vld), .i_num(r_b_num_b),
        .i_den(r_fade_steps), .o_valid(div_vld_b), .o_quot(e_b)
    );

    logic            exp_vld_r, exp_vld_g, exp_vld_b;
    logic [CH_W-1:0] lvl_r, lvl_g, lvl_b;

    rfg_exp #(.FRAC_BITS(FRAC_BITS)) u_exp_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(div_vld_r), .i_e(e_r),
        .o_valid(exp_vld_r), .o_level(lvl_r)
    );
    rfg_exp #(.FRAC_BITS(FRAC_BITS)) u_exp_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(div_vld_g), .i_e(e_g),
        .o_valid(exp_vld_g), .o_level(lvl_g)
    );
    rfg_exp #(.FRAC_BITS(FRAC_BITS)) u_exp_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(div_vld_b), .i_e(e_b),
        .o_valid(exp_vld_b), .o_level(lvl_b)
    );

    logic               r_out_vld;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] n_color;

    // A curve with zero steps is dark; the divider output is meaningless then.
    assign n_color = (r_fade_steps == '0) ? '0 : {lvl_r, lvl_g, lvl_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= exp_vld_r && exp_vld_g && exp_vld_b;
        end
        r_color <= n_color;
    end

    assign o_valid        = r_out_vld;
    assign o_packed_color = r_color;

endmodule

// ===== sim/tb_rgb_log_fade_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_log_fade_generator_core
// Self-checking bench for the logarithmic RGB fade core: fade steps are fed
// through the start/busy handshake under several register settings, and every
// color beat is compared with a fixed-point prediction of the fade curve.
// ----------------------------------------------------------------------------
module tb_rgb_log_fade_generator_core;
    import rfg_pkg::*;

    localparam int FB       = 16;
    localparam int N_PHASES = 12;
    localparam int PER_PHASE = 108;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [STEP_W-1:0]  i_step_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic [COLOR_W-1:0] o_packed_color;

    rgb_log_fade_generator_core #(.FRAC_BITS(FB)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_step_index   (i_step_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_packed_color (o_packed_color)
    );

    // Local copy of the curve registers.
    logic [15:0] steps_reg;
    logic [7:0]  peak_reg [3];
    logic [63:0] half_roots [FB+1];

    logic [STEP_W-1:0]  pending_steps [$];
    logic [COLOR_W-1:0] expected_colors [$];
    int                 idle_pct = 0;
    int                 mismatches = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Fixed-point log2 of a peak: integer part from the leading one, fraction
    // by repeated squaring of the normalized mantissa.
    function automatic logic [63:0] peak_log2(input logic [7:0] m);
        logic [63:0] k;
        logic [63:0] y;
        logic [63:0] frac;
        k = 0;
        frac = 0;
        while ((64'(m) >> (k + 1)) != 0) k++;
        y = (64'(m) << FB) >> k;
        for (int j = 0; j < FB; j++) begin
            y = (y * y) >> FB;
            frac = frac << 1;
            if (y >= (64'd2 << FB)) begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        return (k << FB) | frac;
    endfunction

    function automatic logic [7:0] channel_level(input logic [7:0] m, input logic [15:0] s);
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] ip;
        logic [63:0] v;
        if (m < 2 || steps_reg == 0) return 8'd0;
        e = (peak_log2(m) * 64'(s)) / 64'(steps_reg);
        ip = e >> FB;
        p = 64'd1 << FB;
        for (int j = 1; j <= FB; j++) begin
            if (e[FB-j]) p = (p * half_roots[j]) >> FB;
        end
        if (ip > 8) ip = 8;
        v = (p << ip) >> FB;
        if (v < 1) return 8'd0;
        v = v - 1;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [COLOR_W-1:0] fade_color(input logic [15:0] step);
        logic [15:0] s;
        s = (step > steps_reg) ? steps_reg : step;
        return {channel_level(peak_reg[0], s), channel_level(peak_reg[1], s),
                channel_level(peak_reg[2], s)};
    endfunction

    // Driver: start stays high until the beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_colors.push_back(fade_color(i_step_index));
            if (!start || !busy) begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_step_index <= pending_steps.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: a color beat lasts one cycle and must be taken then.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color beat %06h", o_packed_color);
            end else begin
                logic [COLOR_W-1:0] want;
                want = expected_colors.pop_front();
                if (o_packed_color !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %06h, got %06h",
                                 want, o_packed_color);
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FADE_STEPS) steps_reg = value;
        else peak_reg[int'(idx) - 1] = value[7:0];
    endtask

    task automatic set_curve(input logic [15:0] n, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        write_reg(CFG_FADE_STEPS, n);
        write_reg(CFG_MAX_RED, {8'd0, r});
        write_reg(CFG_MAX_GREEN, {8'd0, g});
        write_reg(CFG_MAX_BLUE, {8'd0, b});
    endtask

    initial begin
        half_roots[0] = 64'd2 << FB;
        for (int j = 1; j <= FB; j++) half_roots[j] = root_floor(half_roots[j-1] << FB);
        steps_reg = 16'd255;
        for (int c = 0; c < 3; c++) peak_reg[c] = 8'd255;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_pct = (ph < 4) ? 7 : (ph < 8) ? 72 : 0;
            case (ph)
                0: ;  // reset values
                1: set_curve(16'd1, 8'd0, 8'd1, 8'd2);
                2: set_curve(16'd65535, 8'd255, 8'd128, 8'd3);
                3: set_curve(16'd0, 8'd255, 8'd255, 8'd255);
                4: set_curve(16'd255, 8'd255, 8'd0, 8'd255);
                default: set_curve(($urandom_range(3) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(1, 400)),
                                   8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (ph == 0) begin
                pending_steps = '{16'd0, 16'd1, 16'd2, 16'd127, 16'd128, 16'd254,
                                  16'd255, 16'd256, 16'h5555, 16'hAAAA, 16'hFFFF};
            end
            for (int i = 0; i < PER_PHASE; i++) begin
                // Mostly steps on the curve; the rest spread over the whole field.
                if ($urandom_range(9) < 7)
                    pending_steps.push_back(16'($urandom_range(0, steps_reg)));
                else
                    pending_steps.push_back(16'($urandom));
            end
            wait (pending_steps.size() == 0 && !start);
            wait (expected_colors.size() == 0);
        end

        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("rgb_log_fade_generator_core regression: pass");
        end else begin
            $display("rgb_log_fade_generator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("rgb_log_fade_generator_core regression: fail");
        $finish;
    end

endmodule
